// ----- hdl/aes128_pkg.sv -----
// shared types, tables and round functions for the aes-128 encrypt unit
`default_nettype none
package aes128_pkg;

    localparam int NumRounds  = 10;
    localparam int KeyRegHigh = 0;
    localparam int KeyRegLow  = 1;

    typedef logic [127:0] block_t;
    typedef logic [1:0]   cfg_index_t;

    typedef logic [7:0] sbox_tab_t [256];
    localparam sbox_tab_t SboxTab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    typedef logic [7:0] rcon_tab_t [NumRounds];
    localparam rcon_tab_t RconTab = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte n of the block sits at bits 127-8n .. 120-8n
    function automatic logic [7:0] get_byte(input block_t b, input int n);
        get_byte = b[127-8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        sub_word = {SboxTab[v[31:24]], SboxTab[v[23:16]], SboxTab[v[15:8]], SboxTab[v[7:0]]};
    endfunction

    // subbytes followed by shiftrows
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = SboxTab[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_columns = t;
    endfunction

    // next 128-bit round key from the previous one
    function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/aes128_key_sched.sv -----
// round-key schedule: key registers and a one-round-per-cycle expansion
`default_nettype none
module aes128_key_sched (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire aes128_pkg::cfg_index_t     cfg_index,
    input  wire logic [63:0]                cfg_data,
    output aes128_pkg::block_t              round_keys [aes128_pkg::NumRounds+1],
    output logic                            key_ready
);

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    aes128_pkg::block_t rk_reg [aes128_pkg::NumRounds+1];
    logic [3:0]         step_reg;
    logic [3:0]         step_next;

    // key registers; a write to either key register restarts the expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aes128_pkg::cfg_index_t'(aes128_pkg::KeyRegHigh))
                key_high_reg <= cfg_data;
            else if (cfg_index == aes128_pkg::cfg_index_t'(aes128_pkg::KeyRegLow))
                key_low_reg <= cfg_data;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (cfg_we && (cfg_index == aes128_pkg::cfg_index_t'(aes128_pkg::KeyRegHigh) ||
                       cfg_index == aes128_pkg::cfg_index_t'(aes128_pkg::KeyRegLow)))
            step_next = 4'd0;
        else if (step_reg <= 4'(aes128_pkg::NumRounds))
            step_next = step_reg + 4'd1;
    end

    // step 0 loads round key 0, step n derives round key n
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 4'd0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == 4'd0)
            rk_reg[0] <= {key_high_reg, key_low_reg};
        for (int n = 1; n <= aes128_pkg::NumRounds; n++)
        begin
            if (step_reg == 4'(n))
                rk_reg[n] <= aes128_pkg::next_round_key(rk_reg[n-1],
                                                        aes128_pkg::RconTab[n-1]);
        end
    end

    assign round_keys = rk_reg;

    // all round keys derived
    assign key_ready = (step_reg > 4'(aes128_pkg::NumRounds));

endmodule
`default_nettype wire

// ----- hdl/aes128_block_encrypt_unit.sv -----
// aes-128 encrypt unit: top level with an eleven-stage round pipeline
// One block is accepted per cycle when the input is not stalled; a block's ciphertext reaches the output
// after it has passed through all eleven stages (one for the initial key add and one per round,
// the first loaded at the accepting edge), with the pipeline advancing only when its
// output stage is empty or being taken. After reset and after each key write the input
// is stalled while the schedule loads round key 0 and then derives one round key per
// cycle; key writes belong only to times when no block is in flight.
`default_nettype none
module aes128_block_encrypt_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] plain_high,
    input  wire logic [63:0] plain_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      cipher_high,
    output logic [63:0]      cipher_low
);

    localparam int Stages = aes128_pkg::NumRounds + 1;

    aes128_pkg::block_t round_keys [Stages];
    aes128_pkg::block_t state_reg  [Stages];
    logic [Stages-1:0]  valid_reg;
    logic               advance;
    logic               key_ready;

    aes128_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .round_keys (round_keys),
        .key_ready  (key_ready)
    );

    // whole pipeline moves together when the last stage can drain
    assign advance  = !valid_reg[Stages-1] || !out_stall;
    assign in_stall = !advance || !key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[Stages-2:0], in_valid && key_ready};
    end

    // round datapath, initial key add then one round per stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg[0] <= {plain_high, plain_low} ^ round_keys[0];
            for (int n = 1; n < Stages - 1; n++)
                state_reg[n] <= aes128_pkg::mix_columns(aes128_pkg::sub_shift(state_reg[n-1]))
                                ^ round_keys[n];
            state_reg[Stages-1] <= aes128_pkg::sub_shift(state_reg[Stages-2])
                                   ^ round_keys[Stages-1];
        end
    end

    assign out_valid   = valid_reg[Stages-1];
    assign cipher_high = state_reg[Stages-1][127:64];
    assign cipher_low  = state_reg[Stages-1][63:0];

endmodule
`default_nettype wire

// ----- hdl/aes128_checker.sv -----
// port-level checker for the aes-128 encrypt unit and its bind
`default_nettype none
module aes128_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] cipher_high,
    input wire logic [63:0] cipher_low
);

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
        else $error("stalled output changed");

    // a stalled output transaction stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output stalled");

    // handshake signals are always known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid, out_stall}))
        else $error("unknown handshake signal");

    // a valid result carries known data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({cipher_high, cipher_low}))
        else $error("unknown ciphertext on valid output");

endmodule

bind aes128_block_encrypt_unit aes128_checker u_aes128_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
);
`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the aes-128 encrypt unit
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int CfgBadIndex = 3;
    localparam int CfgSpareIndex = 2;
    localparam int LongHoldCycles = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;

    aes128_block_encrypt_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .plain_high(plain_high), .plain_low(plain_low),
        .out_valid(out_valid), .out_stall(out_stall),
        .cipher_high(cipher_high), .cipher_low(cipher_low)
    );

    // predictor state
    logic [63:0] key_hi_q, key_lo_q;
    logic [31:0] sched [44];
    logic [7:0]  sbox_lut [256];
    logic [7:0]  rcon_lut [10];
    logic [127:0] cipher_q [$];

    int  errors;
    int  cycles;
    bit  stall_rand_en;
    bit  gap_en;
    int  hold_cycles;
    bit  long_hold;
    event hold_ev;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] v);
        return {sbox_lut[v[31:24]], sbox_lut[v[23:16]], sbox_lut[v[15:8]], sbox_lut[v[7:0]]};
    endfunction

    // rebuild the 44-word key schedule
    task automatic expand_schedule();
        logic [31:0] t;
        sched[0] = key_hi_q[63:32];
        sched[1] = key_hi_q[31:0];
        sched[2] = key_lo_q[63:32];
        sched[3] = key_lo_q[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = sched[i-1];
            if (i % 4 == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon_lut[i/4-1], 24'h0};
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    // forward cipher of one block, byte 0 in the top bits
    function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8];
        for (int rnd = 0; rnd <= 10; rnd++)
        begin
            if (rnd > 0)
            begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[4*c+w] = sbox_lut[s[4*((c+w)%4)+w]];
                s = t;
                if (rnd < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        x = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
                        s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
                        s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
                        s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    s[4*c+w] ^= sched[4*rnd+c][31-8*w -: 8];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout");
            $display("[aes128_block_encrypt_unit] ERROR");
            $finish;
        end
    end

    // predict on each accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            cipher_q.push_back(encrypt_block({plain_high, plain_low}));
    end

    // check each accepted output transaction
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                report_mismatch("unexpected cipher_high", cipher_high, 64'h0);
            end
            else
            begin
                want = cipher_q.pop_front();
                if (cipher_high !== want[127:64])
                    report_mismatch("cipher_high", cipher_high, want[127:64]);
                if (cipher_low !== want[63:0])
                    report_mismatch("cipher_low", cipher_low, want[63:0]);
            end
        end
    end

    // long receiver hold, counted in cycles
    always
    begin
        @(hold_ev);
        long_hold = 1'b1;
        repeat (LongHoldCycles) @(negedge clk);
        long_hold = 1'b0;
    end

    // receiver stall: random bursts, or a long hold when requested
    always @(negedge clk)
    begin
        if (long_hold)
        begin
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (stall_rand_en && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= $urandom_range(0, 7);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        if (gap_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        plain_high <= hi;
        plain_low  <= lo;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        idle_input();
        while (cipher_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // register write while idle, predictor follows
    task automatic write_reg(input int idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == aes128_pkg::KeyRegHigh) key_hi_q = val;
        else if (idx == aes128_pkg::KeyRegLow) key_lo_q = val;
        if (idx == aes128_pkg::KeyRegHigh || idx == aes128_pkg::KeyRegLow) expand_schedule();
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // known vector and field extremes under the reset key
    task automatic test_reset_key_extremes();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        drain();
    endtask

    // standard vector and key extremes, partial updates, ignored index
    task automatic test_key_settings();
        write_reg(aes128_pkg::KeyRegHigh, 64'h2b7e1516_28aed2a6);
        write_reg(aes128_pkg::KeyRegLow, 64'habf71588_09cf4f3c);
        send_block(64'h3243f6a8_885a308d, 64'h313198a2_e0370734);
        send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff);
        drain();
        write_reg(aes128_pkg::KeyRegHigh, '1);
        write_reg(aes128_pkg::KeyRegLow, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain();
        write_reg(aes128_pkg::KeyRegLow, 64'h0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        write_reg(CfgBadIndex, 64'hdead_beef_dead_beef);
        write_reg(CfgSpareIndex, 64'h1234);
        send_block(64'h0, '1);
        drain();
    endtask

    // random blocks with random idling on both sides, key changes between phases
    task automatic test_random_traffic(input int n);
        gap_en = 1;
        stall_rand_en = 1;
        for (int p = 0; p < 4; p++)
        begin
            write_reg($urandom_range(aes128_pkg::KeyRegHigh, aes128_pkg::KeyRegLow), rand64());
            for (int i = 0; i < n / 4; i++) send_block(rand64(), rand64());
            drain();
        end
    endtask

    // long receiver hold while the sender keeps offering, then sender pause
    task automatic test_backpressure();
        gap_en = 0;
        stall_rand_en = 0;
        -> hold_ev;
        for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
        drain();
        for (int i = 0; i < 100; i++) send_block(rand64(), rand64());
        drain();
    endtask

    initial begin
        for (int i = 0; i < 256; i++) sbox_lut[i] = aes128_pkg::SboxTab[i];
        for (int i = 0; i < 10; i++) rcon_lut[i] = aes128_pkg::RconTab[i];
        clk = 1'b0;
        errors = 0;
        cycles = 0;
        stall_rand_en = 0;
        gap_en = 0;
        hold_cycles = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        plain_high = '0;
        plain_low = '0;
        out_stall = 1'b0;
        key_hi_q = '0;
        key_lo_q = '0;
        expand_schedule();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (20) @(negedge clk);

        test_reset_key_extremes();
        test_key_settings();
        test_random_traffic(880);
        test_backpressure();

        if (errors == 0)
            $display("[aes128_block_encrypt_unit] OK");
        else
            $display("[aes128_block_encrypt_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
